// ----- hdl/dcts_pkg.sv -----
// dcts_pkg: shared types and codes for the directory tag store
// no dependencies
package dcts_pkg;

  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    ActLookup     = 2'd0,
    ActList       = 2'd1,
    ActReplace    = 2'd2,
    ActInvalidate = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    StHitSet     = 4'd0,
    StAllocated  = 4'd1,
    StHitVictim  = 4'd2,
    StMiss       = 4'd3,
    StReplaced   = 4'd4,
    StListFull   = 4'd5,
    StNotFound   = 4'd6,
    StInvalid    = 4'd7,
    StCandidate  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    RegLogBlock  = 2'd0,
    RegLogCtrl   = 2'd1,
    RegLogCores  = 2'd2,
    RegLogStack  = 2'd3
  } reg_e;

endpackage

// ----- hdl/directory_cache_tag_store_top.sv -----
// directory_cache_tag_store_top: set-associative directory tag store
// an accepted item passes the hash, set read, compare and output states in that order
// a new item is taken only in the idle state, once the last result of the one before is
//   taken; a list item gives one result per way, read out in turn, tlast on the last way
// reset: a clearing pass zeroes every set row, with the input not ready until it ends
// depends on dcts_pkg
module directory_cache_tag_store_top #(
  parameter int unsigned NUM_SETS     = 256,
  parameter int unsigned WAYS         = 8,
  parameter int unsigned VICTIM_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave: tdata = action[1:0], address[49:2], new_address[97:50], zero fill to 104
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  // master: tdata = status[3:0], in_victim_list[4], slot[8:5], set_number[16:9],
  //   entry_address[64:17], entry_valid[65], zero fill to 72
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // configuration write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [5:0]   cfg_data_i
);

  localparam int unsigned LgSets = $clog2(NUM_SETS) > 0 ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SetW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VicW   = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
  localparam int unsigned AW     = dcts_pkg::AddrW;
  localparam int unsigned Lg     = $clog2(NUM_SETS + 1) - 1;
  localparam int unsigned NRows  = NUM_SETS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_LIST, S_OUT
  } state_e;

  // configuration registers
  logic [3:0] log_block_q, log_ctrl_q, log_cores_q;
  logic [5:0] log_stack_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_block_q <= 4'd6;
      log_ctrl_q  <= 4'd0;
      log_cores_q <= 4'd4;
      log_stack_q <= 6'd20;
    end else if (cfg_valid_i) begin
      unique case (dcts_pkg::reg_e'(cfg_index_i))
        dcts_pkg::RegLogBlock: log_block_q <= cfg_data_i[3:0];
        dcts_pkg::RegLogCtrl:  log_ctrl_q  <= cfg_data_i[3:0];
        dcts_pkg::RegLogCores: log_cores_q <= cfg_data_i[3:0];
        dcts_pkg::RegLogStack: log_stack_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // way memory: one row per set, tags and valid bits
  logic [WAYS*AW-1:0] tag_mem [NRows];
  logic [WAYS-1:0]    row_valid_q [NRows];
  logic [WAYS*AW-1:0] tag_rd_q;
  logic [WAYS-1:0]    val_rd_q;
  logic               mem_we;
  logic [SetW-1:0]    mem_addr;
  logic [WAYS*AW-1:0] tag_wr;
  logic [WAYS-1:0]    val_wr;

  always_ff @(posedge clk_i) begin
    if (mem_we) tag_mem[mem_addr] <= tag_wr;
    tag_rd_q <= tag_mem[mem_addr];
  end

  // valid bits, cleared by the pass after reset
  always_ff @(posedge clk_i) begin
    if (mem_we) row_valid_q[mem_addr] <= val_wr;
    val_rd_q <= row_valid_q[mem_addr];
  end

  // replaced list in flops, compared in parallel
  logic [AW-1:0]           vic_tag_q [VICTIM_DEPTH];
  logic [VICTIM_DEPTH-1:0] vic_val_q;

  // item registers
  state_e          state_q;
  logic [SetW-1:0] clr_q;
  logic [1:0]      act_q;
  logic [AW-1:0]   addr_q, naddr_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] idx_q;
  logic [3:0]      st_q, slot_q;
  logic            vic_q, ev_q, last_q;
  logic [AW-1:0]   eaddr_q;

  // set hash, computed from registered address
  logic [5:0]      c_w, s_w;
  logic [6:0]      lb_w, lbs_w;
  logic [AW-1:0]   core_w, sub_w, sup_w, cmask_w, smask_w;
  logic [AW-1:0]   hash_w;

  always_comb begin
    c_w     = (7'(log_cores_q) <= 7'(Lg)) ? 6'(log_cores_q) : 6'(Lg);
    s_w     = 6'(Lg) - c_w;
    lb_w    = 7'(log_block_q) + 7'(log_ctrl_q);
    lbs_w   = lb_w + 7'(s_w);
    cmask_w = ~({AW{1'b1}} << c_w);
    smask_w = ~({AW{1'b1}} << s_w);
    core_w  = (addr_q >> log_stack_q) & cmask_w;
    sub_w   = (addr_q >> lb_w) & smask_w;
    sup_w   = (addr_q >> lbs_w) & cmask_w;
    hash_w  = ((core_w ^ sup_w) << s_w) + sub_w;
  end

  // compare logic on read row
  logic [WAYS-1:0]         hit_w, free_w;
  logic [VICTIM_DEPTH-1:0] vhit_w, vfree_w;
  logic                    any_hit, any_free, any_vhit, any_vfree;
  logic [WayW-1:0]         hit_i, free_i;
  logic [VicW-1:0]         vhit_i, vfree_i;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_w[w]  = val_rd_q[w] && (tag_rd_q[w*AW +: AW] == addr_q);
      free_w[w] = !val_rd_q[w];
    end
    for (int v = 0; v < VICTIM_DEPTH; v++) begin
      vhit_w[v]  = vic_val_q[v] && (vic_tag_q[v] == addr_q);
      vfree_w[v] = !vic_val_q[v];
    end
    any_hit = |hit_w; any_free = |free_w; any_vhit = |vhit_w; any_vfree = |vfree_w;
    hit_i = '0; free_i = '0; vhit_i = '0; vfree_i = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_w[w])  hit_i  = WayW'(w);
      if (free_w[w]) free_i = WayW'(w);
    end
    for (int v = VICTIM_DEPTH - 1; v >= 0; v--) begin
      if (vhit_w[v])  vhit_i  = VicW'(v);
      if (vfree_w[v]) vfree_i = VicW'(v);
    end
  end

  // result fields of the evaluated item
  logic [3:0]    res_st_w, res_slot_w;
  logic          res_vic_w, res_val_w;
  logic [AW-1:0] res_addr_w;

  always_comb begin
    res_st_w   = dcts_pkg::StMiss;
    res_slot_w = '0;
    res_vic_w  = 1'b0;
    res_val_w  = 1'b0;
    res_addr_w = '0;
    unique case (dcts_pkg::action_e'(act_q))
      dcts_pkg::ActLookup: begin
        if (any_hit) begin
          res_st_w = dcts_pkg::StHitSet; res_slot_w = 4'(hit_i);
          res_addr_w = addr_q; res_val_w = 1'b1;
        end else if (any_free) begin
          res_st_w = dcts_pkg::StAllocated; res_slot_w = 4'(free_i);
          res_addr_w = addr_q; res_val_w = 1'b1;
        end else if (any_vhit) begin
          res_st_w = dcts_pkg::StHitVictim; res_slot_w = 4'(vhit_i); res_vic_w = 1'b1;
          res_addr_w = addr_q; res_val_w = 1'b1;
        end
      end
      dcts_pkg::ActList: res_st_w = dcts_pkg::StCandidate;
      dcts_pkg::ActReplace: begin
        if (!any_hit) res_st_w = dcts_pkg::StNotFound;
        else if (!any_vfree) res_st_w = dcts_pkg::StListFull;
        else begin
          res_st_w = dcts_pkg::StReplaced; res_slot_w = 4'(hit_i);
          res_addr_w = naddr_q; res_val_w = 1'b1;
        end
      end
      dcts_pkg::ActInvalidate: begin
        if (any_vhit) begin
          res_st_w = dcts_pkg::StInvalid; res_slot_w = 4'(vhit_i); res_vic_w = 1'b1;
          res_addr_w = addr_q; res_val_w = 1'b1;
        end else res_st_w = dcts_pkg::StNotFound;
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = set_q;
    tag_wr   = tag_rd_q;
    val_wr   = val_rd_q;
    if (state_q == S_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_q;
      tag_wr   = '0;
      val_wr   = '0;
    end else if (state_q == S_EVAL) begin
      if (dcts_pkg::action_e'(act_q) == dcts_pkg::ActLookup && !any_hit && any_free) begin
        mem_we = 1'b1;
        tag_wr[free_i*AW +: AW] = addr_q;
        val_wr[free_i] = 1'b1;
      end else if (dcts_pkg::action_e'(act_q) == dcts_pkg::ActReplace &&
                   any_hit && any_vfree) begin
        mem_we = 1'b1;
        tag_wr[hit_i*AW +: AW] = naddr_q;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {6'd0, ev_q, eaddr_q, 8'(set_q), slot_q, vic_q, st_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      vic_val_q <= '0;
      act_q <= '0; idx_q <= '0; last_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SetW'(NRows - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          act_q   <= s_axis_tdata[1:0];
          addr_q  <= s_axis_tdata[49:2];
          naddr_q <= s_axis_tdata[97:50];
          state_q <= S_HASH;
        end
        S_HASH: begin
          set_q   <= SetW'(hash_w);
          state_q <= S_READ;
        end
        S_READ: state_q <= S_EVAL;
        S_EVAL: begin
          st_q    <= res_st_w;
          slot_q  <= res_slot_w;
          vic_q   <= res_vic_w;
          eaddr_q <= res_addr_w;
          ev_q    <= res_val_w;
          last_q  <= 1'b1;
          idx_q   <= '0;
          if (dcts_pkg::action_e'(act_q) == dcts_pkg::ActList) state_q <= S_LIST;
          else state_q <= S_OUT;
          // replaced list update
          if (dcts_pkg::action_e'(act_q) == dcts_pkg::ActReplace && any_hit && any_vfree) begin
            vic_val_q[vfree_i] <= 1'b1;
            vic_tag_q[vfree_i] <= addr_q;
          end
          if (dcts_pkg::action_e'(act_q) == dcts_pkg::ActInvalidate && any_vhit) begin
            vic_val_q[vhit_i] <= 1'b0;
          end
        end
        S_LIST: begin
          st_q    <= dcts_pkg::StCandidate;
          slot_q  <= 4'(idx_q);
          vic_q   <= 1'b0;
          ev_q    <= val_rd_q[idx_q];
          eaddr_q <= val_rd_q[idx_q] ? tag_rd_q[idx_q*AW +: AW] : '0;
          last_q  <= (32'(idx_q) == WAYS - 1);
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          if (last_q) state_q <= S_IDLE;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_LIST;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic unused_w;
  assign unused_w = ^{LgSets, s_axis_tdata[103:98]};

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for the directory tag store, with a set-hash
// and replaced-list predictor, random stalls on both streams and config phases
// depends on dcts_pkg and directory_cache_tag_store_top
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NSETS  = 256;
  localparam int unsigned NWAYS  = 8;
  localparam int unsigned NVICT  = 16;
  localparam int unsigned LGSETS = 8;
  localparam longint      LIMIT  = 600000;

  typedef struct packed {
    logic [47:0]       new_address;
    logic [47:0]       address;
    dcts_pkg::action_e action;
  } item_t;

  typedef struct packed {
    logic [47:0]       entry_address;
    logic              entry_valid;
    dcts_pkg::status_e status;
    logic              in_victim;
    logic [3:0]        slot;
    logic [7:0]        set_number;
    logic              last;
  } res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [5:0]   cfg_data_i = '0;

  directory_cache_tag_store_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [47:0] tag_q [NSETS*NWAYS];
  bit          tag_v [NSETS*NWAYS];
  logic [47:0] vic_q [NVICT];
  bit          vic_v [NVICT];
  int unsigned lg_block = 6, lg_ctrl = 0, lg_cores = 4, lg_stack = 20;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    errors = 0;
  int    send_idle_pct = 0, recv_stall_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_cnt = 0;
  longint cycles = 0;

  // addresses used so far, so lookups and replaces find real entries
  logic [47:0] seen_addrs[$];

  function automatic logic [63:0] shr64(logic [63:0] v, int unsigned n);
    return (n >= 64) ? 64'd0 : (v >> n);
  endfunction

  function automatic logic [63:0] lowmask(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [7:0] hash_set(logic [47:0] a);
    int unsigned c, s, lb;
    logic [63:0] core, sub, sup;
    c = (lg_cores <= LGSETS) ? lg_cores : LGSETS;
    s = LGSETS - c;
    lb = lg_block + lg_ctrl;
    core = shr64({16'd0, a}, lg_stack) & lowmask(c);
    sub  = shr64({16'd0, a}, lb) & lowmask(s);
    sup  = shr64({16'd0, a}, lb + s) & lowmask(c);
    return 8'((((core ^ sup) << s) + sub) & lowmask(LGSETS));
  endfunction

  function automatic void push_res(dcts_pkg::status_e st, bit vl, int unsigned sl,
                                   logic [7:0] st_n, logic [47:0] ad, bit ev, bit lst);
    res_t r;
    r.status = st; r.in_victim = vl; r.slot = 4'(sl); r.set_number = st_n;
    r.entry_address = ad; r.entry_valid = ev; r.last = lst;
    expected_results = {expected_results, r};
  endfunction

  // tag store behavior for one accepted item
  function automatic void predict_tag_store(item_t it);
    logic [7:0] set;
    int unsigned base, j;
    set = hash_set(it.address);
    base = set * NWAYS;
    case (it.action)
      dcts_pkg::ActLookup: begin
        for (int i = 0; i < NWAYS; i++)
          if (tag_v[base+i] && tag_q[base+i] == it.address) begin
            push_res(dcts_pkg::StHitSet, 0, i, set, it.address, 1, 1);
            return;
          end
        for (int i = 0; i < NWAYS; i++)
          if (!tag_v[base+i]) begin
            tag_v[base+i] = 1; tag_q[base+i] = it.address;
            push_res(dcts_pkg::StAllocated, 0, i, set, it.address, 1, 1);
            return;
          end
        for (int i = 0; i < NVICT; i++)
          if (vic_v[i] && vic_q[i] == it.address) begin
            push_res(dcts_pkg::StHitVictim, 1, i, set, it.address, 1, 1);
            return;
          end
        push_res(dcts_pkg::StMiss, 0, 0, set, '0, 0, 1);
      end
      dcts_pkg::ActList: begin
        for (int i = 0; i < NWAYS; i++)
          push_res(dcts_pkg::StCandidate, 0, i, set, tag_v[base+i] ? tag_q[base+i] : '0,
                   tag_v[base+i], i == NWAYS-1);
      end
      dcts_pkg::ActReplace: begin
        for (int i = 0; i < NWAYS; i++)
          if (tag_v[base+i] && tag_q[base+i] == it.address) begin
            for (j = 0; j < NVICT; j++) if (!vic_v[j]) break;
            if (j >= NVICT) begin
              push_res(dcts_pkg::StListFull, 0, 0, set, '0, 0, 1);
              return;
            end
            vic_v[j] = 1; vic_q[j] = it.address;
            tag_q[base+i] = it.new_address;
            push_res(dcts_pkg::StReplaced, 0, i, set, it.new_address, 1, 1);
            return;
          end
        push_res(dcts_pkg::StNotFound, 0, 0, set, '0, 0, 1);
      end
      default: begin
        for (int i = 0; i < NVICT; i++)
          if (vic_v[i] && vic_q[i] == it.address) begin
            vic_v[i] = 0;
            push_res(dcts_pkg::StInvalid, 1, i, set, it.address, 1, 1);
            return;
          end
        push_res(dcts_pkg::StNotFound, 0, 0, set, '0, 0, 1);
      end
    endcase
  endfunction

  // accepted input items feed the predictor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_tag_store(item_t'(s_axis_tdata[97:0]));
      void'(pending_items.pop_front());
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (pending_items.size() != 0 &&
                 (s_axis_tvalid || $urandom_range(99) >= send_idle_pct)) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {6'd0, pending_items[0]};
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_req) hold_cnt <= 300;
  end

  // receiver ready
  always @(negedge clk_i) begin
    if (!rst_ni || hold_cnt != 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t exp_r, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = dcts_pkg::status_e'(m_axis_tdata[3:0]);
      got.in_victim = m_axis_tdata[4];
      got.slot = m_axis_tdata[8:5];
      got.set_number = m_axis_tdata[16:9];
      got.entry_address = m_axis_tdata[64:17];
      got.entry_valid = m_axis_tdata[65];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: status %0d/%0d vict %0b/%0b slot %0d/%0d set %0d/%0d",
                      " addr %h/%h v %0b/%0b last %0b/%0b"},
                     exp_r.status, got.status, exp_r.in_victim, got.in_victim,
                     exp_r.slot, got.slot, exp_r.set_number, got.set_number,
                     exp_r.entry_address, got.entry_address, exp_r.entry_valid,
                     got.entry_valid, exp_r.last, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("FAIL directory_cache_tag_store_top");
      $finish;
    end
  end

  function automatic logic [47:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // mostly reuse known addresses so hits, replaces and invalidates occur
  function automatic logic [47:0] pick_addr();
    logic [47:0] a;
    if (seen_addrs.size() != 0 && $urandom_range(99) < 65)
      return seen_addrs[$urandom_range(seen_addrs.size()-1)];
    // narrow addresses crowd a few sets so ways fill up
    if ($urandom_range(1)) a = {28'd0, 4'($urandom), 10'd0, 6'($urandom)};
    else a = rand_addr();
    seen_addrs = {seen_addrs, a};
    return a;
  endfunction

  task automatic add_item(dcts_pkg::action_e act, logic [47:0] a, logic [47:0] na);
    item_t it;
    it.action = act; it.address = a; it.new_address = na;
    pending_items = {pending_items, it};
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(dcts_pkg::reg_e idx, logic [5:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dcts_pkg::RegLogBlock: lg_block = val[3:0];
      dcts_pkg::RegLogCtrl:  lg_ctrl = val[3:0];
      dcts_pkg::RegLogCores: lg_cores = val[3:0];
      default:               lg_stack = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_items(int n);
    dcts_pkg::action_e act;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      act = (r < 40) ? dcts_pkg::ActLookup : (r < 50) ? dcts_pkg::ActList :
            (r < 80) ? dcts_pkg::ActReplace : dcts_pkg::ActInvalidate;
      add_item(act, pick_addr(), ($urandom_range(1)) ? pick_addr() : rand_addr());
    end
  endtask

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) tag_v[i] = 0;
    for (int i = 0; i < NVICT; i++) vic_v[i] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every action, full set
    add_item(dcts_pkg::ActList, 48'd0, 48'd0);
    add_item(dcts_pkg::ActLookup, 48'hFFFF_FFFF_FFFF, 48'd0);
    add_item(dcts_pkg::ActLookup, 48'hFFFF_FFFF_FFFF, 48'd0);
    add_item(dcts_pkg::ActInvalidate, 48'h1234, 48'd0);
    add_item(dcts_pkg::ActReplace, 48'h5555_5555_5555, 48'd1);
    for (int i = 0; i < 9; i++) add_item(dcts_pkg::ActLookup, 48'(i) << 14, 48'd0);
    add_item(dcts_pkg::ActReplace, 48'd0, 48'hAAAA_AAAA_AAAA);
    add_item(dcts_pkg::ActLookup, 48'd0, 48'd0);
    add_item(dcts_pkg::ActInvalidate, 48'd0, 48'd0);
    add_item(dcts_pkg::ActList, 48'd0, 48'd0);
    add_item(dcts_pkg::ActReplace, 48'hFFFF_FFFF_FFFF, 48'h0);
    drain();

    // fill the replaced list up to overflow: replace within one set repeatedly
    for (int i = 0; i < 18; i++)
      add_item(dcts_pkg::ActReplace, (i == 0) ? 48'h4000 : 48'h1_0000_0000 + 48'(i-1),
               48'h1_0000_0000 + 48'(i));
    add_item(dcts_pkg::ActLookup, 48'h4000, 48'd0);
    drain();

    // random phase at reset config, no idling
    random_items(35);
    drain();

    // long receiver hold-off while items keep coming
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 1'b1;
    random_items(10);
    wait (hold_cnt != 0);
    hold_req = 1'b0;
    wait (hold_cnt == 0);
    drain();

    write_reg(dcts_pkg::RegLogBlock, 6'd0);
    write_reg(dcts_pkg::RegLogCtrl, 6'd0);
    write_reg(dcts_pkg::RegLogCores, 6'd0);
    write_reg(dcts_pkg::RegLogStack, 6'd0);
    send_idle_pct = 78;
    random_items(30);
    drain();

    write_reg(dcts_pkg::RegLogBlock, 6'd12);
    write_reg(dcts_pkg::RegLogCtrl, 6'd8);
    write_reg(dcts_pkg::RegLogCores, 6'd10);
    write_reg(dcts_pkg::RegLogStack, 6'd40);
    send_idle_pct = 0; recv_stall_pct = 78;
    random_items(30);
    drain();

    write_reg(dcts_pkg::RegLogBlock, 6'd15);
    write_reg(dcts_pkg::RegLogCtrl, 6'd15);
    write_reg(dcts_pkg::RegLogCores, 6'd15);
    write_reg(dcts_pkg::RegLogStack, 6'd63);
    send_idle_pct = 32; recv_stall_pct = 32;
    random_items(20);
    drain();

    write_reg(dcts_pkg::RegLogBlock, 6'($urandom_range(12)));
    write_reg(dcts_pkg::RegLogCtrl, 6'($urandom_range(8)));
    write_reg(dcts_pkg::RegLogCores, 6'($urandom_range(10)));
    write_reg(dcts_pkg::RegLogStack, 6'($urandom_range(40)));
    send_idle_pct = 0; recv_stall_pct = 0;
    random_items(30);
    drain();

    if (errors == 0) begin
      $display("PASS directory_cache_tag_store_top");
    end else begin
      $display("FAIL directory_cache_tag_store_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dcts_pkg.sv
hdl/directory_cache_tag_store_top.sv
verif/tb_top.sv
